// ----- design/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator: request and
// response beats, the classified command, table entry layouts and codes.
// ----------------------------------------------------------------------------
package gha_pkg;

   // Sizing
   localparam int CAPACITY = 1024;
   localparam int GEN_BITS = 8;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Queue depths between the parts
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Request opcodes (code 3 is unused)
   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_CHECK   = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [IDX_W-1:0]    entity_index;
      logic [GEN_BITS-1:0] entity_generation;
      logic                null_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [IDX_W-1:0]    out_index;
      logic [GEN_BITS-1:0] out_generation;
      logic [CNT_W-1:0]    live_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_CREATE,
      CMD_DESTROY,
      CMD_CHECK,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [IDX_W-1:0]    idx;
      logic [GEN_BITS-1:0] gen;
      logic                null_handle;
   } cmd_type;

   // Generation table entry: occupied flag plus the slot's generation
   typedef struct packed {
      logic                live;
      logic [GEN_BITS-1:0] gen;
   } slot_type;

   // Free stack entry: slot index plus the generation it will carry on reuse
   typedef struct packed {
      logic [IDX_W-1:0]    idx;
      logic [GEN_BITS-1:0] gen;
   } free_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } bk_state_type;

endpackage

// ----- design/generational_handle_allocator.sv -----
// Path: a request beat is registered in the input queue, taken by the engine, and
//   its response is written into the response queue; either queue can stall it. The
//   engine takes no new request until the last is written back (registered RAM read).
// Input and response queues of two beats each decouple both sides from the engine.
// Reset: synchronous; clears counters and queues. Tables need no clearing pass,
//   so requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot-map handle allocator: create, destroy and check of generational
// handles, with a LIFO of freed slots and a high-water mark of fresh slots.
// ----------------------------------------------------------------------------
module generational_handle_allocator import gha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    rsp_push;
   rsp_type rsp_beat;
   logic    rsp_full;

   // Decode and buffer requests
   gha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Allocation engine
   gha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_out   (rsp_beat),
      .rsp_full  (rsp_full)
   );

   // Buffer responses
   gha_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_beat),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ----- design/gha_ram.sv -----
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gha_front.sv -----
// ----------------------------------------------------------------------------
// gha_front
// Request side: decodes each request beat into a command and holds it in a
// short queue until the engine takes it.
// ----------------------------------------------------------------------------
module gha_front import gha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int OCC_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type          ent_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   cmd_type          decoded;
   logic             do_push;
   logic             do_pop;

   // Classify the request
   always_comb begin
      decoded.idx         = req_data.entity_index;
      decoded.gen         = req_data.entity_generation;
      decoded.null_handle = req_data.null_handle;
      unique case (req_data.opcode)
         OP_CREATE:  decoded.kind = CMD_CREATE;
         OP_DESTROY: decoded.kind = CMD_DESTROY;
         OP_CHECK:   decoded.kind = CMD_CHECK;
         default:    decoded.kind = CMD_NONE;
      endcase
   end

   assign full      = (occ_ff == OCC_W'(CMD_QUEUE_DEPTH));
   assign cmd_valid = (occ_ff != '0);
   assign cmd       = ent_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- design/gha_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// gha_rsp_queue
// Response side: short queue of finished response beats, so the engine can
// run on while the consumer stalls.
// ----------------------------------------------------------------------------
module gha_rsp_queue import gha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_in,
   output logic    rsp_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int OCC_W = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_type          ent_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             do_push;
   logic             do_pop;

   assign rsp_full = (occ_ff == OCC_W'(RSP_QUEUE_DEPTH));
   assign empty    = (occ_ff == '0);
   assign rsp_data = ent_ff[rd_ptr_ff];
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (do_pop && !do_push) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ----- design/gha_back.sv -----
// ----------------------------------------------------------------------------
// gha_back
// Allocation engine: reads the generation table and the free stack for one
// command, then writes back, updates the counters and emits the response.
// ----------------------------------------------------------------------------
module gha_back import gha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_out,
   input  logic    rsp_full
);

   localparam int SLOT_W = $bits(slot_type);
   localparam int FREE_W = $bits(free_type);

   bk_state_type     state_ff, state_in;
   cmd_type          cmd_ff;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] high_water_ff, high_water_in;
   logic [CNT_W-1:0] alive_ff, alive_in;

   logic             rd_en;
   logic [IDX_W-1:0] stk_rd_addr;
   slot_type         slot_rd;
   free_type         free_rd;
   logic             slot_wr_en;
   logic [IDX_W-1:0] slot_wr_addr;
   slot_type         slot_wr;
   logic             free_wr_en;
   free_type         free_wr;
   logic             hit;
   logic [GEN_BITS-1:0] gen_next;

   // Per-slot generation and occupied flag
   gha_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr),
      .rd_en   (rd_en),
      .rd_addr (cmd.idx),
      .rd_data (slot_rd)
   );

   // LIFO of freed slots, each with the generation it comes back with
   gha_ram #(.WIDTH(FREE_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_count_ff[IDX_W-1:0]),
      .wr_data (free_wr),
      .rd_en   (rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (free_rd)
   );

   // Top of stack; wraps harmlessly when the stack is empty
   assign stk_rd_addr = free_count_ff[IDX_W-1:0] - IDX_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs: take a command only with room for its response
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop  = cmd_valid && !rsp_full;
         BK_EXEC: rsp_push = 1'b1;
         default: cmd_pop  = 1'b0;
      endcase
   end

   assign rd_en = cmd_pop;

   // Handle validity against the table entry just read
   assign hit = !cmd_ff.null_handle
             && ({1'b0, cmd_ff.idx} < high_water_ff)
             && slot_rd.live
             && (slot_rd.gen == cmd_ff.gen);
   assign gen_next = slot_rd.gen + GEN_BITS'(1);

   // Execute: write-back, counters and response
   always_comb begin
      free_count_in          = free_count_ff;
      high_water_in          = high_water_ff;
      alive_in               = alive_ff;
      slot_wr_en             = 1'b0;
      slot_wr_addr           = cmd_ff.idx;
      slot_wr                = '0;
      free_wr_en             = 1'b0;
      free_wr                = '0;
      rsp_out.status         = ST_INVALID;
      rsp_out.out_index      = cmd_ff.idx;
      rsp_out.out_generation = cmd_ff.gen;
      if (state_ff == BK_EXEC) begin
         unique case (cmd_ff.kind)
            CMD_CREATE: begin
               priority if (free_count_ff != '0) begin
                  // reuse the most recently freed slot
                  slot_wr_en             = 1'b1;
                  slot_wr_addr           = free_rd.idx;
                  slot_wr                = '{live: 1'b1, gen: free_rd.gen};
                  free_count_in          = free_count_ff - CNT_W'(1);
                  alive_in               = alive_ff + CNT_W'(1);
                  rsp_out.status         = ST_OK;
                  rsp_out.out_index      = free_rd.idx;
                  rsp_out.out_generation = free_rd.gen;
               end else if (high_water_ff != CNT_W'(CAPACITY)) begin
                  // fresh slot at generation zero
                  slot_wr_en             = 1'b1;
                  slot_wr_addr           = high_water_ff[IDX_W-1:0];
                  slot_wr                = '{live: 1'b1, gen: '0};
                  high_water_in          = high_water_ff + CNT_W'(1);
                  alive_in               = alive_ff + CNT_W'(1);
                  rsp_out.status         = ST_OK;
                  rsp_out.out_index      = high_water_ff[IDX_W-1:0];
                  rsp_out.out_generation = '0;
               end else begin
                  rsp_out.status = ST_FULL;
               end
            end
            CMD_DESTROY: begin
               if (hit && (free_count_ff != CNT_W'(CAPACITY))) begin
                  slot_wr_en     = 1'b1;
                  slot_wr        = '{live: 1'b0, gen: gen_next};
                  free_wr_en     = 1'b1;
                  free_wr        = '{idx: cmd_ff.idx, gen: gen_next};
                  free_count_in  = free_count_ff + CNT_W'(1);
                  alive_in       = (alive_ff != '0) ? alive_ff - CNT_W'(1) : alive_ff;
                  rsp_out.status = ST_OK;
               end
            end
            CMD_CHECK: rsp_out.status = hit ? ST_OK : ST_INVALID;
            default:   rsp_out.status = ST_INVALID;
         endcase
      end
      rsp_out.live_count = alive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         free_count_ff <= '0;
         high_water_ff <= '0;
         alive_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         alive_ff      <= alive_in;
      end
   end

   // Command held through the table read
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
   end

   // Checks
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into a full queue");

   a_exec_follows_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff == BK_EXEC && rsp_push)
      else $error("taken command did not produce a response");

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_count_ff} + {1'b0, alive_ff}) == {1'b0, high_water_ff})
      else $error("free plus live slots differ from issued slots");

   a_high_water_cap: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= CNT_W'(CAPACITY))
      else $error("high-water mark beyond capacity");

   a_create_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_push && cmd_ff.kind == CMD_CREATE && rsp_out.status == ST_OK
      |=> alive_ff == $past(alive_ff) + CNT_W'(1))
      else $error("successful create did not raise the live count");

endmodule

// ----- tb/tb_generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Self-checking bench for the handle allocator. A planner builds the request
// stream ahead of time from its own view of the allocator, so that destroys
// and checks mostly carry live or recently freed handles. A second view of the
// allocator predicts each response as request beats are taken by the block,
// and responses are compared field by field in order. Both sides idle at
// random; the sink holds off long enough to back up the block, and the source
// waits for the block to drain at chosen points.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator import gha_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [IDX_W+GEN_BITS-1:0] handle_type;

   // Two views of the allocator: one drives planning, one scores responses
   localparam int PLAN_VIEW  = 0;
   localparam int SCORE_VIEW = 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Allocator state per view
   logic [GEN_BITS-1:0] gen_tab [2][CAPACITY];
   logic [IDX_W-1:0]    free_stk [2][CAPACITY];
   bit                  slot_live [2][CAPACITY];
   bit [CNT_W-1:0]      free_cnt [2];
   bit [CNT_W-1:0]      high_mark [2];
   bit [CNT_W-1:0]      alive_cnt [2];

   req_type    pending_reqs[$];
   rsp_type    expected_rsps[$];
   handle_type live_handles[$];
   handle_type dead_handles[$];
   int         drain_marks[$];

   int req_count = 0;
   int rsp_count = 0;
   int fail_count = 0;

   generational_handle_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // A handle is valid only if non-null, issued, occupied and of matching generation
   function automatic bit handle_live(input int v, input logic [IDX_W-1:0] idx,
                                      input logic [GEN_BITS-1:0] g, input logic nul);
      return !nul && (idx < high_mark[v]) && slot_live[v][idx] && (gen_tab[v][idx] == g);
   endfunction

   // One request against one view; returns the response it must produce
   function automatic rsp_type alloc_predict(input int v, input req_type rq);
      rsp_type          rs;
      logic [IDX_W-1:0] slot;
      rs.status         = ST_INVALID;
      rs.out_index      = rq.entity_index;
      rs.out_generation = rq.entity_generation;
      case (rq.opcode)
         OP_CREATE: begin
            if (free_cnt[v] != 0) begin
               // reuse the most recently freed slot with its stored generation
               free_cnt[v]        = free_cnt[v] - 1'b1;
               slot               = free_stk[v][free_cnt[v]];
               slot_live[v][slot] = 1'b1;
               alive_cnt[v]       = alive_cnt[v] + 1'b1;
               rs.out_index       = slot;
               rs.out_generation  = gen_tab[v][slot];
               rs.status          = ST_OK;
            end else if (high_mark[v] < CAPACITY) begin
               slot               = high_mark[v][IDX_W-1:0];
               gen_tab[v][slot]   = '0;
               slot_live[v][slot] = 1'b1;
               high_mark[v]       = high_mark[v] + 1'b1;
               alive_cnt[v]       = alive_cnt[v] + 1'b1;
               rs.out_index       = slot;
               rs.out_generation  = '0;
               rs.status          = ST_OK;
            end else begin
               rs.status = ST_FULL;
            end
         end
         OP_DESTROY: begin
            if (handle_live(v, rq.entity_index, rq.entity_generation, rq.null_handle)) begin
               gen_tab[v][rq.entity_index]   = gen_tab[v][rq.entity_index] + 1'b1;
               slot_live[v][rq.entity_index] = 1'b0;
               free_stk[v][free_cnt[v]]      = rq.entity_index;
               free_cnt[v]                   = free_cnt[v] + 1'b1;
               if (alive_cnt[v] != 0)
                  alive_cnt[v] = alive_cnt[v] - 1'b1;
               rs.status = ST_OK;
            end
         end
         OP_CHECK: begin
            if (handle_live(v, rq.entity_index, rq.entity_generation, rq.null_handle))
               rs.status = ST_OK;
         end
         default: begin
         end
      endcase
      rs.live_count = alive_cnt[v];
      return rs;
   endfunction

   // Queue one request and keep the planner's lists of live and freed handles
   task automatic plan_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [GEN_BITS-1:0] g, input logic nul);
      req_type rq;
      rsp_type rs;
      int      pos[$];
      rq = '{opcode: op, entity_index: idx, entity_generation: g, null_handle: nul};
      rs = alloc_predict(PLAN_VIEW, rq);
      pending_reqs.insert(pending_reqs.size(), rq);
      if (rs.status == ST_OK && op == OP_CREATE) begin
         live_handles.insert(live_handles.size(), {rs.out_index, rs.out_generation});
      end else if (rs.status == ST_OK && op == OP_DESTROY) begin
         pos = live_handles.find_first_index(h) with (h == {idx, g});
         if (pos.size() != 0)
            live_handles.delete(pos[0]);
         dead_handles.insert(dead_handles.size(), {idx, g});
         if (dead_handles.size() > 64)
            void'(dead_handles.pop_front());
      end
   endtask

   task automatic plan_handle(input logic [1:0] op, input handle_type h, input logic nul);
      plan_req(op, h[IDX_W+GEN_BITS-1:GEN_BITS], h[GEN_BITS-1:0], nul);
   endtask

   task automatic plan_create();
      plan_req(OP_CREATE, IDX_W'($urandom_range(0, CAPACITY - 1)),
               GEN_BITS'($urandom_range(0, (1 << GEN_BITS) - 1)), 1'($urandom_range(0, 1)));
   endtask

   // Mostly well-formed traffic on known handles, with some noise
   task automatic plan_random(input int create_pct);
      int         r;
      logic [1:0] op;
      handle_type h;
      r  = $urandom_range(0, 99);
      op = $urandom_range(0, 1) ? OP_DESTROY : OP_CHECK;
      if (r < create_pct || live_handles.size() == 0) begin
         plan_create();
      end else if (r < create_pct + 25) begin
         h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         plan_handle(OP_DESTROY, h, 1'b0);
      end else if (r < create_pct + 45) begin
         h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         plan_handle(OP_CHECK, h, 1'b0);
      end else if (r < create_pct + 55 && dead_handles.size() != 0) begin
         h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
         plan_handle(op, h, 1'b0);
      end else if (r < create_pct + 60) begin
         // live handle flagged null
         h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         plan_handle(op, h, 1'b1);
      end else begin
         plan_req(2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, CAPACITY - 1)),
                  GEN_BITS'($urandom_range(0, (1 << GEN_BITS) - 1)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   // Idle length: mostly none or short, a few long, and calm stretches with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 149) == 0)
         calm = $urandom_range(30, 80);
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Request side: next beat offered at the falling edge
   always @(negedge clock) begin : req_driver
      int req_seen;
      int req_gap;
      int req_calm;
      bit draining;
      if (reset) begin
         push     <= 1'b0;
         req_seen = 0;
         req_gap  = 0;
         req_calm = 0;
      end else begin
         if (req_count != req_seen) begin
            req_seen = req_count;
            req_gap  = pick_gap(req_calm);
         end
         // at a drain mark, hold until every response has come back
         draining = 1'b0;
         if (drain_marks.size() != 0 && req_count == drain_marks[0]) begin
            if (expected_rsps.size() == 0)
               void'(drain_marks.pop_front());
            else
               draining = 1'b1;
         end
         if (req_gap > 0) begin
            push <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() == 0 || draining) begin
            push <= 1'b0;
         end else begin
            push     <= 1'b1;
            req_data <= pending_reqs[0];
         end
      end
   end

   // Response side: pop changes at the falling edge; two long hold-offs
   always @(negedge clock) begin : rsp_driver
      int rsp_seen;
      int rsp_gap;
      int rsp_calm;
      if (reset) begin
         pop      <= 1'b0;
         rsp_seen = 0;
         rsp_gap  = 0;
         rsp_calm = 0;
      end else begin
         if (rsp_count != rsp_seen) begin
            rsp_seen = rsp_count;
            rsp_gap  = pick_gap(rsp_calm);
            if (rsp_count == 150 || rsp_count == 1300)
               rsp_gap = 150;
         end
         if (rsp_gap > 0) begin
            pop <= 1'b0;
            rsp_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Beats taken at the rising edge: predict requests, score responses
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && push && !full) begin
         expected_rsps.insert(expected_rsps.size(), alloc_predict(SCORE_VIEW, req_data));
         void'(pending_reqs.pop_front());
         req_count++;
      end
      if (!reset && pop && !empty) begin
         if (expected_rsps.size() == 0) begin
            $error("response beat with nothing expected: %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("out_index", want.out_index, rsp_data.out_index);
            check_field("out_generation", want.out_generation, rsp_data.out_generation);
            check_field("live_count", want.live_count, rsp_data.live_count);
         end
         rsp_count++;
      end
   end

   initial begin : main
      handle_type first_h;
      handle_type h;

      // Directed opening
      plan_req(OP_CHECK, '0, '0, 1'b0);             // nothing issued yet
      plan_create();
      plan_create();
      plan_create();
      plan_req(OP_CHECK, 10'd1, 8'd0, 1'b0);        // valid
      plan_req(OP_CHECK, 10'd1, 8'd0, 1'b1);        // null beats valid fields
      plan_req(OP_CHECK, 10'd1, 8'd5, 1'b0);        // wrong generation
      plan_req(OP_CHECK, '1, '1, 1'b0);             // above high-water mark
      plan_req(OP_DESTROY, 10'd1, 8'd0, 1'b1);      // null destroy refused
      plan_req(OP_DESTROY, 10'd1, 8'd0, 1'b0);
      plan_req(OP_DESTROY, 10'd1, 8'd0, 1'b0);      // double destroy
      plan_req(OP_CHECK, 10'd1, 8'd1, 1'b0);        // freed slot, generation matches
      plan_req(OP_DESTROY, 10'd0, 8'd0, 1'b0);
      plan_create();                                // reuses slot 0
      plan_create();                                // reuses slot 1
      plan_create();                                // fresh slot 3
      plan_req(2'd3, 10'd2, 8'd0, 1'b0);            // unused opcode
      plan_req(2'd3, '1, '1, 1'b1);
      plan_req(OP_DESTROY, '1, '1, 1'b0);
      plan_req(OP_CHECK, 10'd2, 8'd0, 1'b0);
      drain_marks.insert(drain_marks.size(), pending_reqs.size());

      // Mixed traffic, growing the population
      repeat (80)
         plan_random(40);

      // Use up every slot, then ask for more
      while (!(high_mark[PLAN_VIEW] == CAPACITY && free_cnt[PLAN_VIEW] == 0))
         plan_create();
      repeat (4)
         plan_create();
      drain_marks.insert(drain_marks.size(), pending_reqs.size());

      // Cycle one slot through a full generation wrap; the old handle comes back
      first_h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      h       = first_h;
      repeat (1 << GEN_BITS) begin
         plan_handle(OP_DESTROY, h, 1'b0);
         plan_create();
         h = live_handles[$];
      end
      plan_handle(OP_CHECK, first_h, 1'b0);

      // Mixed traffic near capacity
      repeat (60)
         plan_random(30);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
